// ----- hw/rtl/fuzzy_gain_pd_steering_defines.svh -----
// Assertion macros shared by the steering controller RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef FUZZY_GAIN_PD_STEERING_DEFINES_SVH
`define FUZZY_GAIN_PD_STEERING_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define FGPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define FGPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fgps_pkg.sv -----
// Types, constants and helper functions for the fuzzy PD steering controller.
// No dependencies.
package fgps_pkg;

    localparam int LEVELS_DEF = 5;
    localparam int MAX_LVL    = 5;
    localparam logic [2:0] CODE_NONE = 3'd5;

    typedef enum logic [2:0] {
        REG_CENTER  = 3'd0,
        REG_PSCALE  = 3'd1,
        REG_DSCALE  = 3'd2,
        REG_EBP     = 3'd3,
        REG_CBP     = 3'd4,
        REG_PLVL    = 3'd5,
        REG_DLVL    = 3'd6
    } cfg_reg_t;

    localparam logic [39:0] EBP_RESET = 40'h32_19_00_E7_CE;
    localparam logic [39:0] CBP_RESET = 40'h19_0F_00_F1_E7;

    // Segment lookup result: index, full-weight flag, numerator and divisor.
    typedef struct packed {
        logic [2:0] idx;
        logic       full;
        logic [7:0] num;
        logic [7:0] den;
    } seg_t;

    localparam logic [2:0] KP_RULES [6][6] = '{
        '{3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd5},
        '{3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd5},
        '{3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd5},
        '{3'd3, 3'd2, 3'd1, 3'd1, 3'd0, 3'd5},
        '{3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd5},
        '{3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5}
    };

    localparam logic [2:0] KD_RULES [6][6] = '{
        '{3'd3, 3'd1, 3'd0, 3'd0, 3'd3, 3'd5},
        '{3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd5},
        '{3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd5},
        '{3'd3, 3'd2, 3'd2, 3'd2, 3'd3, 3'd5},
        '{3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd5},
        '{3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5}
    };

    function automatic logic [2:0] rule_code(input logic use_d, input logic [2:0] row,
                                             input logic [2:0] col);
        logic [2:0] code;
        code = CODE_NONE;
        if (row <= 3'd5 && col <= 3'd5) begin
            code = use_d ? KD_RULES[row][col] : KP_RULES[row][col];
        end
        return code;
    endfunction

    // Place x among five breakpoints; first matching segment wins.
    function automatic seg_t seg_find(input logic signed [9:0] x, input logic [39:0] bp);
        logic signed [9:0]  b [5];
        logic signed [10:0] d;
        logic signed [10:0] n;
        logic               found;
        seg_t               s;
        for (int k = 0; k < 5; k++) begin
            b[k] = {{2{bp[8*k+7]}}, bp[8*k +: 8]};
        end
        s = '{idx: 3'd4, full: 1'b1, num: 8'd0, den: 8'd1};
        found = 1'b0;
        if (x < b[0]) begin
            s.idx = 3'd0;
            found = 1'b1;
        end
        for (int k = 0; k < 4; k++) begin
            if (!found && x < b[k+1]) begin
                found = 1'b1;
                s.idx = 3'(k);
                d = 11'(b[k+1]) - 11'(b[k]);
                n = 11'(b[k+1]) - 11'(x);
                if (d > 11'sd0 && n != d) begin
                    s.full = 1'b0;
                    s.num  = n[7:0];
                    s.den  = d[7:0];
                end
            end
        end
        return s;
    endfunction

    // One restoring division step: {quotient bit, new remainder}.
    function automatic logic [8:0] div_step(input logic [7:0] r, input logic [7:0] den);
        logic [8:0] t;
        logic [8:0] res;
        t = {r, 1'b0};
        if (t >= {1'b0, den}) begin
            res = {1'b1, 8'(t - {1'b0, den})};
        end else begin
            res = {1'b0, t[7:0]};
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/fuzzy_gain_pd_steering.sv -----
// Fuzzy self-tuning PD steering controller, thirteen-stage pipeline.
// Depends on fgps_pkg and fuzzy_gain_pd_steering_defines.svh.
//
// Usage:
//   Input channel: in_valid / in_stall carry one request of error, error_change
//   and previous_error. A request is taken at a clock edge with in_valid high
//   and in_stall low. Output channel: out_valid / out_stall carry
//   steering_command, p_gain and d_gain, taken when out_valid && !out_stall.
//   Configuration: cfg_write, cfg_index, cfg_data write one register per edge;
//   write only while the pipeline is empty. Unknown indexes are dropped.
// Timing:
//   One request per cycle sustained while out_stall stays low. From acceptance,
//   a request passes through one segment stage, three stages of a 16-bit
//   restoring divider (6, 5 and 5 bits) per input, then weight products, level
//   sums, level products, defuzzify sum, abs/saturate, two multiply stages,
//   correction sum and the output register, where it can be taken.
//   The divider, five or six restoring steps per stage, sets the pipeline depth.
// Reset:
//   rst_n clears all stage valid bits and loads register defaults (center 0,
//   scales 1.0, default breakpoints, zero levels).
// Back-pressure:
//   Each stage holds while it is full and the stage after it holds; bubbles
//   close up, so requests keep entering until every stage is full. Then
//   in_stall rises and nothing is lost or repeated.
`include "fuzzy_gain_pd_steering_defines.svh"

module fuzzy_gain_pd_steering
    import fgps_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [59:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [9:0]  error,
    input  logic signed [9:0]  error_change,
    input  logic signed [9:0]  previous_error,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] steering_command,
    output logic [10:0]        p_gain,
    output logic [10:0]        d_gain
);

    localparam int NUM_LVL = (LEVELS < MAX_LVL) ? LEVELS : MAX_LVL;
    localparam int NS      = 13;

    // Configuration registers.
    logic [14:0] center_reg;
    logic [15:0] pscale_reg;
    logic [15:0] dscale_reg;
    logic [39:0] ebp_reg;
    logic [39:0] cbp_reg;
    logic [59:0] plvl_reg;
    logic [59:0] dlvl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            pscale_reg <= 16'd256;
            dscale_reg <= 16'd256;
            ebp_reg    <= EBP_RESET;
            cbp_reg    <= CBP_RESET;
            plvl_reg   <= '0;
            dlvl_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER: center_reg <= cfg_data[14:0];
                REG_PSCALE: pscale_reg <= cfg_data[15:0];
                REG_DSCALE: dscale_reg <= cfg_data[15:0];
                REG_EBP:    ebp_reg    <= cfg_data[39:0];
                REG_CBP:    cbp_reg    <= cfg_data[39:0];
                REG_PLVL:   plvl_reg   <= cfg_data;
                REG_DLVL:   dlvl_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Stage valid bits and the advance chain.
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] adv;

    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 1: segment search. Lane 0 is the error, lane 1 the change.
    seg_t seg_next [2];
    assign seg_next[0] = seg_find(error, ebp_reg);
    assign seg_next[1] = seg_find(error_change, cbp_reg);

    logic signed [9:0]  e1_reg;
    logic signed [10:0] de1_reg;
    logic [2:0]         idx1_reg  [2];
    logic               full1_reg [2];
    logic [7:0]         rem1_reg  [2];
    logic [7:0]         den1_reg  [2];

    // Stages 2..4: divider, carried fields.
    logic signed [9:0]  e2_reg, e3_reg, e4_reg;
    logic signed [10:0] de2_reg, de3_reg, de4_reg;
    logic [2:0]         idx2_reg [2], idx3_reg [2], idx4_reg [2];
    logic               full2_reg [2], full3_reg [2], full4_reg [2];
    logic [7:0]         rem2_reg [2], rem3_reg [2];
    logic [7:0]         den2_reg [2], den3_reg [2];
    logic [15:0]        q2_reg [2], q3_reg [2], q4_reg [2];

    logic [7:0]  rem2_next [2], rem3_next [2];
    logic [15:0] q2_next [2], q3_next [2], q4_next [2];

    always_comb
    begin
        logic [8:0] st;
        logic [7:0] rem4;
        for (int j = 0; j < 2; j++) begin
            rem2_next[j] = rem1_reg[j];
            q2_next[j]   = '0;
            for (int s = 0; s < 6; s++) begin
                st           = div_step(rem2_next[j], den1_reg[j]);
                q2_next[j]   = {q2_next[j][14:0], st[8]};
                rem2_next[j] = st[7:0];
            end
            rem3_next[j] = rem2_reg[j];
            q3_next[j]   = q2_reg[j];
            for (int s = 0; s < 5; s++) begin
                st           = div_step(rem3_next[j], den2_reg[j]);
                q3_next[j]   = {q3_next[j][14:0], st[8]};
                rem3_next[j] = st[7:0];
            end
            rem4       = rem3_reg[j];
            q4_next[j] = q3_reg[j];
            for (int s = 0; s < 5; s++) begin
                st         = div_step(rem4, den3_reg[j]);
                q4_next[j] = {q4_next[j][14:0], st[8]};
                rem4       = st[7:0];
            end
        end
    end

    // Stage 5: weights and products.
    logic [16:0] we, wc, we_n, wc_n;
    assign we   = full4_reg[0] ? 17'h10000 : {1'b0, q4_reg[0]};
    assign wc   = full4_reg[1] ? 17'h10000 : {1'b0, q4_reg[1]};
    assign we_n = 17'h10000 - we;
    assign wc_n = 17'h10000 - wc;

    logic [33:0] wp_full [4];
    assign wp_full[0] = we * wc;
    assign wp_full[1] = we * wc_n;
    assign wp_full[2] = we_n * wc;
    assign wp_full[3] = we_n * wc_n;

    logic [2:0] pcode_next [4], dcode_next [4];
    always_comb
    begin
        for (int j = 0; j < 4; j++) begin
            pcode_next[j] = rule_code(1'b0, idx4_reg[0] + 3'(j / 2), idx4_reg[1] + 3'(j % 2));
            dcode_next[j] = rule_code(1'b1, idx4_reg[0] + 3'(j / 2), idx4_reg[1] + 3'(j % 2));
        end
    end

    logic signed [9:0]  e5_reg;
    logic signed [10:0] de5_reg;
    logic [32:0]        wp5_reg [4];
    logic [2:0]         pcode5_reg [4], dcode5_reg [4];

    // Stage 6: per-level weight sums.
    logic [32:0] pacc_next [NUM_LVL], dacc_next [NUM_LVL];
    always_comb
    begin
        for (int l = 0; l < NUM_LVL; l++) begin
            pacc_next[l] = '0;
            dacc_next[l] = '0;
            for (int j = 0; j < 4; j++) begin
                if (pcode5_reg[j] == 3'(l))
                begin
                    pacc_next[l] = pacc_next[l] + wp5_reg[j];
                end
                if (dcode5_reg[j] == 3'(l))
                begin
                    dacc_next[l] = dacc_next[l] + wp5_reg[j];
                end
            end
        end
    end

    logic signed [9:0]  e6_reg;
    logic signed [10:0] de6_reg;
    logic [32:0]        pacc6_reg [NUM_LVL], dacc6_reg [NUM_LVL];

    // Stage 7: weight sum times level.
    logic signed [45:0] pprod_next [NUM_LVL], dprod_next [NUM_LVL];
    always_comb
    begin
        logic signed [33:0] a;
        logic signed [11:0] lv;
        for (int l = 0; l < NUM_LVL; l++) begin
            a             = {1'b0, pacc6_reg[l]};
            lv            = plvl_reg[12*l +: 12];
            pprod_next[l] = a * lv;
            a             = {1'b0, dacc6_reg[l]};
            lv            = dlvl_reg[12*l +: 12];
            dprod_next[l] = a * lv;
        end
    end

    logic signed [9:0]  e7_reg;
    logic signed [10:0] de7_reg;
    logic signed [45:0] pprod7_reg [NUM_LVL], dprod7_reg [NUM_LVL];

    // Stage 8: defuzzify sum.
    logic signed [45:0] psum_next, dsum_next;
    always_comb
    begin
        psum_next = '0;
        dsum_next = '0;
        for (int l = 0; l < NUM_LVL; l++) begin
            psum_next = psum_next + pprod7_reg[l];
            dsum_next = dsum_next + dprod7_reg[l];
        end
    end

    logic signed [9:0]  e8_reg;
    logic signed [10:0] de8_reg;
    logic signed [45:0] psum8_reg, dsum8_reg;

    // Stage 9: absolute value, drop the fraction, saturate to Q3.8.
    logic [45:0] pmag, dmag;
    logic [10:0] pg_next, dg_next;
    assign pmag    = psum8_reg[45] ? 46'(-psum8_reg) : 46'(psum8_reg);
    assign dmag    = dsum8_reg[45] ? 46'(-dsum8_reg) : 46'(dsum8_reg);
    assign pg_next = (pmag[45:32] > 14'd2047) ? 11'd2047 : pmag[42:32];
    assign dg_next = (dmag[45:32] > 14'd2047) ? 11'd2047 : dmag[42:32];

    logic signed [9:0]  e9_reg;
    logic signed [10:0] de9_reg;
    logic [10:0]        pg9_reg, dg9_reg;

    // Stage 10: scale the gains.
    logic [26:0]        ps10_reg, ds10_reg;
    logic signed [9:0]  e10_reg;
    logic signed [10:0] de10_reg;
    logic [10:0]        pg10_reg, dg10_reg;

    // Stage 11: multiply by error and error difference.
    logic signed [27:0] ps_s, ds_s;
    logic signed [37:0] tp_next;
    logic signed [38:0] td_next;
    assign ps_s    = {1'b0, ps10_reg};
    assign ds_s    = {1'b0, ds10_reg};
    assign tp_next = ps_s * e10_reg;
    assign td_next = ds_s * de10_reg;

    logic signed [37:0] tp11_reg;
    logic signed [38:0] td11_reg;
    logic [10:0]        pg11_reg, dg11_reg;

    // Stage 12: total, truncated toward zero.
    logic signed [39:0] total;
    logic signed [39:0] biased;
    logic signed [23:0] corr_next;
    assign total     = 40'(tp11_reg) + 40'(td11_reg);
    assign biased    = total + (total[39] ? 40'sd65535 : 40'sd0);
    assign corr_next = biased[39:16];

    logic signed [23:0] corr12_reg;
    logic [10:0]        pg12_reg, dg12_reg;

    // Stage 13: add center and saturate.
    logic signed [24:0] cmd;
    logic signed [15:0] cmd_sat;
    assign cmd = 25'(signed'({1'b0, center_reg})) + 25'(corr12_reg);
    always_comb
    begin
        if (cmd > 25'sd32767)
        begin
            cmd_sat = 16'sh7FFF;
        end
        else if (cmd < -25'sd32768)
        begin
            cmd_sat = 16'sh8000;
        end
        else
        begin
            cmd_sat = cmd[15:0];
        end
    end

    logic signed [15:0] cmd13_reg;
    logic [10:0]        pg13_reg, dg13_reg;

    assign steering_command = cmd13_reg;
    assign p_gain           = pg13_reg;
    assign d_gain           = dg13_reg;

    // Payload registers: advance with their stage, no reset.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            e1_reg  <= error;
            de1_reg <= 11'(error) - 11'(previous_error);
            for (int j = 0; j < 2; j++) begin
                idx1_reg[j]  <= seg_next[j].idx;
                full1_reg[j] <= seg_next[j].full;
                rem1_reg[j]  <= seg_next[j].num;
                den1_reg[j]  <= seg_next[j].den;
            end
        end
        if (adv[1])
        begin
            e2_reg  <= e1_reg;
            de2_reg <= de1_reg;
            for (int j = 0; j < 2; j++) begin
                idx2_reg[j]  <= idx1_reg[j];
                full2_reg[j] <= full1_reg[j];
                rem2_reg[j]  <= rem2_next[j];
                den2_reg[j]  <= den1_reg[j];
                q2_reg[j]    <= q2_next[j];
            end
        end
        if (adv[2])
        begin
            e3_reg  <= e2_reg;
            de3_reg <= de2_reg;
            for (int j = 0; j < 2; j++) begin
                idx3_reg[j]  <= idx2_reg[j];
                full3_reg[j] <= full2_reg[j];
                rem3_reg[j]  <= rem3_next[j];
                den3_reg[j]  <= den2_reg[j];
                q3_reg[j]    <= q3_next[j];
            end
        end
        if (adv[3])
        begin
            e4_reg  <= e3_reg;
            de4_reg <= de3_reg;
            for (int j = 0; j < 2; j++) begin
                idx4_reg[j]  <= idx3_reg[j];
                full4_reg[j] <= full3_reg[j];
                q4_reg[j]    <= q4_next[j];
            end
        end
        if (adv[4])
        begin
            e5_reg  <= e4_reg;
            de5_reg <= de4_reg;
            for (int j = 0; j < 4; j++) begin
                wp5_reg[j]    <= wp_full[j][32:0];
                pcode5_reg[j] <= pcode_next[j];
                dcode5_reg[j] <= dcode_next[j];
            end
        end
        if (adv[5])
        begin
            e6_reg  <= e5_reg;
            de6_reg <= de5_reg;
            for (int l = 0; l < NUM_LVL; l++) begin
                pacc6_reg[l] <= pacc_next[l];
                dacc6_reg[l] <= dacc_next[l];
            end
        end
        if (adv[6])
        begin
            e7_reg  <= e6_reg;
            de7_reg <= de6_reg;
            for (int l = 0; l < NUM_LVL; l++) begin
                pprod7_reg[l] <= pprod_next[l];
                dprod7_reg[l] <= dprod_next[l];
            end
        end
        if (adv[7])
        begin
            e8_reg    <= e7_reg;
            de8_reg   <= de7_reg;
            psum8_reg <= psum_next;
            dsum8_reg <= dsum_next;
        end
        if (adv[8])
        begin
            e9_reg  <= e8_reg;
            de9_reg <= de8_reg;
            pg9_reg <= pg_next;
            dg9_reg <= dg_next;
        end
        if (adv[9])
        begin
            e10_reg  <= e9_reg;
            de10_reg <= de9_reg;
            ps10_reg <= 27'(pscale_reg) * 27'(pg9_reg);
            ds10_reg <= 27'(dscale_reg) * 27'(dg9_reg);
            pg10_reg <= pg9_reg;
            dg10_reg <= dg9_reg;
        end
        if (adv[10])
        begin
            tp11_reg <= tp_next;
            td11_reg <= td_next;
            pg11_reg <= pg10_reg;
            dg11_reg <= dg10_reg;
        end
        if (adv[11])
        begin
            corr12_reg <= corr_next;
            pg12_reg   <= pg11_reg;
            dg12_reg   <= dg11_reg;
        end
        if (adv[12])
        begin
            cmd13_reg <= cmd_sat;
            pg13_reg  <= pg12_reg;
            dg13_reg  <= dg12_reg;
        end
    end

    // Four weight products always split exactly one unit of weight.
    logic [34:0] wp_total;
    assign wp_total = 35'(wp5_reg[0]) + 35'(wp5_reg[1]) + 35'(wp5_reg[2]) + 35'(wp5_reg[3]);

    `FGPS_ASSERT_NOW(a_weight_unit, vld_reg[4], wp_total == 35'h1_0000_0000,
                     "weight products do not sum to one")
    `FGPS_ASSERT_NOW(a_stall_full, in_stall, &vld_reg, "input held while a stage is empty")
    `FGPS_ASSERT_NEXT(a_no_phantom, !in_valid && vld_reg == '0, !out_valid,
                      "result appeared from an empty pipeline")

endmodule
